/* rtl/bra_pkg.sv */
package bra_pkg;

  localparam int MAP_BYTES_DEF = 512;
  localparam int SLOT_BITS     = 8;
  localparam int REQ_W         = 2;
  localparam int INDEX_W       = 32;
  localparam int RUN_LEN_W     = 13;
  localparam int STATUS_W      = 2;
  localparam int USED_W        = 10;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam logic [USED_W-1:0] USED_RESET = 10'd512;

  localparam logic [REQ_W-1:0] REQ_TEST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USED = 2'd1;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_CLR   = 5'd0;
  localparam step_t S_IDLE  = 5'd1;
  localparam step_t S_DISP  = 5'd2;
  localparam step_t S_DISP2 = 5'd3;
  localparam step_t S_DISP3 = 5'd4;
  localparam step_t S_RANGE = 5'd5;
  localparam step_t S_BADDR = 5'd6;
  localparam step_t S_BRD   = 5'd7;
  localparam step_t S_BRES  = 5'd8;
  localparam step_t S_EMIT  = 5'd9;
  localparam step_t S_A0    = 5'd10;
  localparam step_t S_A1    = 5'd11;
  localparam step_t S_SCAN  = 5'd12;
  localparam step_t S_A3    = 5'd13;
  localparam step_t S_NOSP  = 5'd14;
  localparam step_t S_M0    = 5'd15;
  localparam step_t S_M1    = 5'd16;
  localparam step_t S_MARK  = 5'd17;
  localparam step_t S_MEND  = 5'd18;

  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NOT_END   = 4'd2,
    C_NOT_START = 4'd3,
    C_ALLOC     = 4'd4,
    C_NONE      = 4'd5,
    C_IDX_OK    = 4'd6,
    C_NO_RUN    = 4'd7,
    C_SCAN_MORE = 4'd8,
    C_HIT       = 4'd9,
    C_MARK_MORE = 4'd10
  } cond_t;

  typedef enum logic [2:0] {
    A_HOLD  = 3'd0,
    A_ZERO  = 3'd1,
    A_INC   = 3'd2,
    A_IDX   = 3'd3,
    A_FOUND = 3'd4
  } addr_op_t;

  typedef enum logic [1:0] {
    W_NONE = 2'd0,
    W_ZERO = 2'd1,
    W_BIT  = 2'd2,
    W_MARK = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic     rd;
    addr_op_t aop;
    wr_sel_t  wsel;
    logic     scan;
    logic     scan_init;
    logic     calc_found;
    logic     set_bit;
    logic     set_start;
    logic     st_range;
    logic     st_nospace;
    logic     emit;
    cond_t    cond;
    step_t    target;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t u;
    u = '0;
    u.aop  = A_HOLD;
    u.wsel = W_NONE;
    u.cond = C_NEVER;
    unique case (s)
      S_CLR: begin
        u.wsel = W_ZERO; u.aop = A_INC; u.cond = C_NOT_END; u.target = S_CLR;
      end
      S_IDLE: begin
        u.aop = A_ZERO; u.cond = C_NOT_START; u.target = S_IDLE;
      end
      S_DISP: begin
        u.cond = C_ALLOC; u.target = S_A0;
      end
      S_DISP2: begin
        u.cond = C_NONE; u.target = S_EMIT;
      end
      S_DISP3: begin
        u.cond = C_IDX_OK; u.target = S_BADDR;
      end
      S_RANGE: begin
        u.st_range = 1'b1; u.emit = 1'b1; u.cond = C_ALWAYS; u.target = S_IDLE;
      end
      S_BADDR: begin
        u.aop = A_IDX;
      end
      S_BRD: begin
        u.rd = 1'b1;
      end
      S_BRES: begin
        u.set_bit = 1'b1; u.wsel = W_BIT; u.emit = 1'b1;
        u.cond = C_ALWAYS; u.target = S_IDLE;
      end
      S_EMIT: begin
        u.emit = 1'b1; u.cond = C_ALWAYS; u.target = S_IDLE;
      end
      S_A0: begin
        u.aop = A_ZERO; u.scan_init = 1'b1; u.cond = C_NO_RUN; u.target = S_NOSP;
      end
      S_A1: begin
        u.rd = 1'b1; u.aop = A_INC;
      end
      S_SCAN: begin
        u.rd = 1'b1; u.aop = A_INC; u.scan = 1'b1;
        u.cond = C_SCAN_MORE; u.target = S_SCAN;
      end
      S_A3: begin
        u.calc_found = 1'b1; u.cond = C_HIT; u.target = S_M0;
      end
      S_NOSP: begin
        u.st_nospace = 1'b1; u.emit = 1'b1; u.cond = C_ALWAYS; u.target = S_IDLE;
      end
      S_M0: begin
        u.aop = A_FOUND; u.set_start = 1'b1;
      end
      S_M1: begin
        u.rd = 1'b1; u.aop = A_INC;
      end
      S_MARK: begin
        u.rd = 1'b1; u.aop = A_INC; u.wsel = W_MARK;
        u.cond = C_MARK_MORE; u.target = S_MARK;
      end
      S_MEND: begin
        u.emit = 1'b1; u.cond = C_ALWAYS; u.target = S_IDLE;
      end
      default: begin
        u.cond = C_ALWAYS; u.target = S_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

/* rtl/bra_ram.sv */
module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bitmap_run_allocator.sv */
// first-fit bitmap allocator over a map of MAP_BYTES bytes, one bit per slot,
// held in a single-port-read RAM and run by a small microcode sequencer.
// after reset the block sweeps the map to zero, one byte a cycle, with busy
// high. a request is taken on start while busy is low; its result shows on
// bit_value, run_start and status for the one cycle that done is high, and
// the receiver cannot stall it. a test or write checks the index, then reads
// the addressed map byte and, for a write, updates it; an index out of range
// is reported without reading the map. an allocate scans the map up to the
// end of the first run found and then marks the bytes that run covers; both
// passes go through the map RAM read port, one byte per cycle.
module bitmap_run_allocator #(
  parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [bra_pkg::REQ_W-1:0]       req_type,
  input  logic [bra_pkg::INDEX_W-1:0]     slot_index,
  input  logic                            write_value,
  input  logic [bra_pkg::RUN_LEN_W-1:0]   run_length,
  output logic                            done,
  output logic                            bit_value,
  output logic [bra_pkg::INDEX_W-1:0]     run_start,
  output logic [bra_pkg::STATUS_W-1:0]    status
);

  import bra_pkg::*;

  localparam int AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int SW    = AW + 3;
  localparam int LW    = RUN_LEN_W;
  localparam int CW    = ((SW > LW) ? SW : LW) + 1;
  localparam int ACT_W = $clog2(MAP_BYTES + 1);
  localparam int UCW   = (ACT_W > USED_W) ? ACT_W : USED_W;

  step_t pc;
  step_t pc_next;
  ucode_t ctl;

  logic [INDEX_W-1:0]   base_index;
  logic [USED_W-1:0]    used_bytes;

  logic [REQ_W-1:0]     req_r;
  logic [INDEX_W-1:0]   idx_r;
  logic                 wv_r;
  logic [LW-1:0]        len_r;

  logic [AW-1:0]        addr;
  logic [AW-1:0]        addr_next;
  logic [AW-1:0]        data_addr;
  logic [AW-1:0]        waddr;
  logic                 we;
  logic [SLOT_BITS-1:0] wdata;
  logic [SLOT_BITS-1:0] rd_data;

  logic [LW-1:0]        run_r;
  logic                 hit_r;
  logic                 last_r;
  logic [SW-1:0]        end_r;
  logic [SW-1:0]        found_r;

  logic [UCW-1:0]       active;
  logic [INDEX_W-1:0]   rel;
  logic                 idx_ok;
  logic                 cond_true;
  logic                 accept;
  logic                 scan_en;

  logic [LW-1:0]        scan_run;
  logic                 scan_hit;
  logic [SW-1:0]        scan_end;
  logic [SLOT_BITS-1:0] mark_mask;
  logic [SLOT_BITS-1:0] bit_mod;

  assign ctl    = ucode_rom(pc);
  assign busy   = (pc != S_IDLE);
  assign accept = start && !busy;

  assign active = (UCW'(used_bytes) > UCW'(MAP_BYTES)) ? UCW'(MAP_BYTES) : UCW'(used_bytes);
  assign rel    = idx_r - base_index;
  assign idx_ok = (idx_r >= base_index) && (32'(rel[31:3]) < 32'(active));

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NOT_END:   cond_true = (addr != AW'(MAP_BYTES - 1));
      C_NOT_START: cond_true = !start;
      C_ALLOC:     cond_true = (req_r == REQ_ALLOC);
      C_NONE:      cond_true = (req_r != REQ_TEST) && (req_r != REQ_WRITE);
      C_IDX_OK:    cond_true = idx_ok;
      C_NO_RUN:    cond_true = (len_r == '0) || (active == '0);
      C_SCAN_MORE: cond_true = !hit_r && !last_r;
      C_HIT:       cond_true = hit_r;
      C_MARK_MORE: cond_true = (data_addr != end_r[SW-1:3]);
      default:     cond_true = 1'b0;
    endcase
  end

  assign pc_next = cond_true ? ctl.target : pc + step_t'(1);

  always_comb begin
    unique case (ctl.aop)
      A_HOLD:  addr_next = addr;
      A_ZERO:  addr_next = '0;
      A_INC:   addr_next = addr + AW'(1);
      A_IDX:   addr_next = rel[AW+2:3];
      A_FOUND: addr_next = found_r[SW-1:3];
      default: addr_next = addr;
    endcase
  end

  // first-fit run search over one map byte
  always_comb begin
    logic [LW-1:0] run_v;
    logic          hit_v;
    logic [SW-1:0] end_v;
    run_v = run_r;
    hit_v = 1'b0;
    end_v = end_r;
    for (int k = 0; k < SLOT_BITS; k++) begin
      if (!hit_v) begin
        if (rd_data[k]) begin
          run_v = '0;
        end else begin
          run_v = run_v + LW'(1);
        end
        if (run_v == len_r) begin
          hit_v = 1'b1;
          end_v = {data_addr, 3'(k)};
        end
      end
    end
    scan_run = run_v;
    scan_hit = hit_v;
    scan_end = end_v;
  end

  always_comb begin
    for (int k = 0; k < SLOT_BITS; k++) begin
      mark_mask[k] = ({data_addr, 3'(k)} >= found_r) && ({data_addr, 3'(k)} <= end_r);
    end
  end

  always_comb begin
    bit_mod = rd_data;
    bit_mod[rel[2:0]] = wv_r;
  end

  always_comb begin
    unique case (ctl.wsel)
      W_NONE: begin
        we = 1'b0; wdata = rd_data; waddr = addr;
      end
      W_ZERO: begin
        we = 1'b1; wdata = '0; waddr = addr;
      end
      W_BIT: begin
        we = (req_r == REQ_WRITE); wdata = bit_mod; waddr = addr;
      end
      W_MARK: begin
        we = 1'b1; wdata = rd_data | mark_mask; waddr = data_addr;
      end
      default: begin
        we = 1'b0; wdata = rd_data; waddr = addr;
      end
    endcase
  end

  assign scan_en = ctl.scan && !hit_r && !last_r;

  bra_ram #(
    .WIDTH(SLOT_BITS),
    .DEPTH(MAP_BYTES)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ctl.rd),
    .raddr(addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= S_CLR;
      addr       <= '0;
      done       <= 1'b0;
      hit_r      <= 1'b0;
      last_r     <= 1'b0;
      base_index <= '0;
      used_bytes <= USED_RESET;
    end else begin
      pc   <= pc_next;
      addr <= addr_next;
      done <= ctl.emit;
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) begin
          base_index <= cfg_data;
        end else if (cfg_index == CFG_USED) begin
          used_bytes <= cfg_data[USED_W-1:0];
        end
      end
      if (ctl.scan_init) begin
        hit_r  <= 1'b0;
        last_r <= 1'b0;
      end else if (scan_en) begin
        hit_r <= scan_hit;
        if (UCW'(data_addr) == active - UCW'(1)) begin
          last_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= req_type;
      idx_r     <= slot_index;
      wv_r      <= write_value;
      len_r     <= run_length;
      bit_value <= 1'b0;
      run_start <= '0;
      status    <= ST_OK;
    end
    if (ctl.rd) begin
      data_addr <= addr;
    end
    if (ctl.scan_init) begin
      run_r <= '0;
    end else if (scan_en) begin
      run_r <= scan_run;
      end_r <= scan_end;
    end
    if (ctl.calc_found) begin
      found_r <= SW'(CW'(end_r) + CW'(1) - CW'(len_r));
    end
    if (ctl.set_start) begin
      run_start <= base_index + INDEX_W'(found_r);
    end
    if (ctl.set_bit) begin
      bit_value <= (req_r == REQ_TEST) ? rd_data[rel[2:0]] : 1'b0;
    end
    if (ctl.st_range) begin
      status <= ST_RANGE;
    end
    if (ctl.st_nospace) begin
      status <= ST_NOSPACE;
    end
  end

endmodule

/* rtl/bra_checker.sv */
module bra_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic                           bit_value,
  input logic [bra_pkg::INDEX_W-1:0]    run_start,
  input logic [bra_pkg::STATUS_W-1:0]   status
);

  import bra_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_RANGE || status == ST_NOSPACE) |->
      !bit_value && run_start == '0)
    else $error("failed request with nonzero result fields");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_RANGE || status == ST_NOSPACE))
    else $error("unknown status code");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .bit_value(bit_value),
  .run_start(run_start),
  .status   (status)
);
